/* rtl/bsa_pkg.sv */
`default_nettype none

package bsa_pkg;

	localparam int SLOT_SIZE_W = 13;
	localparam int CFG_SLOTS_W = 10;
	localparam int REQ_W       = 16;
	localparam int SLOT_NUM_W  = 9;
	localparam int STATUS_W    = 2;
	localparam int OFFSET_W    = 21;
	localparam int IN_USE_W    = 10;
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	localparam logic [SLOT_SIZE_W-1:0] SLOT_SIZE_RST = 13'd16;
	localparam logic [CFG_SLOTS_W-1:0] RESERVED_RST  = 10'd0;
	localparam logic [CFG_SLOTS_W-1:0] ACTIVE_RST    = 10'd512;

	typedef enum logic [1:0] {
		REG_SLOT_SIZE = 2'd0,
		REG_RESERVED  = 2'd1,
		REG_ACTIVE    = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_NO_FREE   = 2'd1,
		STS_TOO_LARGE = 2'd2,
		STS_BAD_FREE  = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_FCHK = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_RESP = 5'b10000
	} state_t;

	typedef struct packed {
		logic [SLOT_SIZE_W-1:0] slot_size;
		logic [CFG_SLOTS_W-1:0] reserved_slots;
		logic [CFG_SLOTS_W-1:0] active_slots;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/bsa_ram.sv */
`default_nettype none

module bsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/bsa_cfg.sv */
`default_nettype none

module bsa_cfg
	import bsa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_size      <= SLOT_SIZE_RST;
			cfg_q.reserved_slots <= RESERVED_RST;
			cfg_q.active_slots   <= ACTIVE_RST;
		end else if (wr) begin
			case (idx)
				REG_SLOT_SIZE: cfg_q.slot_size      <= pwdata[SLOT_SIZE_W-1:0];
				REG_RESERVED:  cfg_q.reserved_slots <= pwdata[CFG_SLOTS_W-1:0];
				REG_ACTIVE:    cfg_q.active_slots   <= pwdata[CFG_SLOTS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SLOT_SIZE: prdata = APB_DATA_W'(cfg_q.slot_size);
			REG_RESERVED:  prdata = APB_DATA_W'(cfg_q.reserved_slots);
			REG_ACTIVE:    prdata = APB_DATA_W'(cfg_q.active_slots);
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/bsa_scan.sv */
`default_nettype none

// Window mask on one bitmap word, then lowest set bit.
module bsa_scan #(
	parameter int WORD_BITS = 64
) (
	input  wire logic [WORD_BITS-1:0]         word,
	input  wire logic                         lo_en,
	input  wire logic [$clog2(WORD_BITS)-1:0] lo_bit,
	input  wire logic                         hi_en,
	input  wire logic [$clog2(WORD_BITS)-1:0] hi_bit,
	output logic                              hit,
	output logic      [$clog2(WORD_BITS)-1:0] idx
);

	localparam int L = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] ones;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] masked;

	assign ones    = '1;
	assign lo_mask = lo_en ? (ones << lo_bit) : ones;
	// bits up to and including hi_bit
	assign hi_mask = hi_en ? (ones >> (~hi_bit)) : ones;
	assign masked  = word & lo_mask & hi_mask;
	assign hit     = |masked;

	always_comb begin
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (masked[i]) begin
				idx = L'(i);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/bitmap_slot_allocator.sv */
// Fixed-size slot allocator over a free bitmap held in a RAM.
// Input stream s_*: one request per beat, operation in s_tuser (0 allocate,
// 1 free), request_size and slot_number in s_tdata. Output stream m_*: one
// response per request, status in m_tuser, slot, offset and use count in
// m_tdata. APB port holds slot_size, reserved_slots, active_slots.
// Requests are handled one at a time; s_tready is high only while idle.
// Allocate: reads bitmap words one word per cycle from the first word of the
// window, stopping at the first word with a free bit in the window or at the
// last window word, then does the offset multiply and loads the response; the
// next request is accepted in the cycle after the response is loaded. Free:
// check and write back, multiply, load. Rejected requests skip the RAM and go
// straight to the multiply and the response load.
// Reset sets every slot free through per-word valid bits (no clearing pass),
// clears the count and loads register defaults. A stalled response sits in
// the output register; the next request is accepted and worked on, then
// waits in the response state until the register frees up.
// WORD_BITS must be a power of two.
`default_nettype none

module bitmap_slot_allocator
	import bsa_pkg::*;
#(
	parameter int NUM_SLOTS = 512,
	parameter int WORD_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// [15:0] request_size, [24:16] slot_number, [31:25] zero
	input  wire logic [31:0]           s_tdata,
	// [0] operation
	input  wire logic [0:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [8:0] granted_slot, [29:9] byte_offset, [30] run_empty,
	// [40:31] slots_in_use, [47:41] zero
	output logic      [47:0]           m_tdata,
	// [1:0] status
	output logic      [1:0]            m_tuser,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int L         = $clog2(WORD_BITS);
	localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
	localparam int SW        = $clog2(NUM_SLOTS);
	localparam int CNTW      = $clog2(NUM_SLOTS + 1);
	localparam int LW        = CNTW > CFG_SLOTS_W ? CNTW : CFG_SLOTS_W;
	localparam int PW        = SW + SLOT_SIZE_W;

	cfg_t cfg;

	bsa_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// window bounds
	logic [LW-1:0] active_ext, limit, reserved_ext, lm1;
	logic          window_empty;
	logic [AW-1:0] r_word, l_word;
	logic [L-1:0]  r_bit, l_bit;

	assign active_ext   = LW'(cfg.active_slots);
	assign limit        = (active_ext > LW'(NUM_SLOTS)) ? LW'(NUM_SLOTS) : active_ext;
	assign reserved_ext = LW'(cfg.reserved_slots);
	assign window_empty = reserved_ext >= limit;
	assign lm1          = limit - LW'(1);
	assign r_word       = AW'(reserved_ext >> L);
	assign r_bit        = reserved_ext[L-1:0];
	assign l_word       = AW'(lm1 >> L);
	assign l_bit        = lm1[L-1:0];

	// request decode
	op_t                 op;
	logic [REQ_W-1:0]    req;
	logic [LW-1:0]       num_ext;
	logic                too_large, bad_free;

	assign op        = op_t'(s_tuser[0]);
	assign req       = s_tdata[15:0];
	assign num_ext   = LW'(s_tdata[24:16]);
	assign too_large = req > REQ_W'(cfg.slot_size);
	assign bad_free  = (num_ext < reserved_ext) || (num_ext >= limit);

	state_t               state_q;
	logic [AW-1:0]        cur_w_q;
	logic [L-1:0]         bit_q;
	status_t              status_q;
	logic [SW-1:0]        slot_q;
	logic [PW-1:0]        prod_q;
	logic [CNTW-1:0]      cnt_q;
	logic [NUM_WORDS-1:0] wv_q;
	logic                 rd_valid_s1;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [SLOT_NUM_W-1:0] out_slot_q;
	logic [OFFSET_W-1:0]   out_off_q;
	logic                  out_empty_q;
	logic [IN_USE_W-1:0]   out_cnt_q;

	// bitmap RAM
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata, word;

	bsa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// never-written words read as all free
	assign word = rd_valid_s1 ? ram_rdata : '1;

	logic         hit;
	logic [L-1:0] hit_idx;

	bsa_scan #(
		.WORD_BITS(WORD_BITS)
	) u_scan (
		.word  (word),
		.lo_en (cur_w_q == r_word),
		.lo_bit(r_bit),
		.hi_en (cur_w_q == l_word),
		.hi_bit(l_bit),
		.hit   (hit),
		.idx   (hit_idx)
	);

	logic accept, out_load;

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid & s_tready;
	assign out_load = (state_q == ST_RESP) && (!out_valid_q || m_tready);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cur_w_q;
		ram_we    = 1'b0;
		ram_waddr = cur_w_q;
		ram_wdata = word;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_ALLOC) begin
						ram_re    = !too_large && !window_empty;
						ram_raddr = r_word;
					end else begin
						ram_re    = !bad_free;
						ram_raddr = AW'(num_ext >> L);
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					ram_we    = 1'b1;
					ram_wdata = word & ~(WORD_BITS'(1) << hit_idx);
				end else if (cur_w_q != l_word) begin
					ram_re    = 1'b1;
					ram_raddr = cur_w_q + AW'(1);
				end
			end
			ST_FCHK: begin
				ram_we    = !word[bit_q];
				ram_wdata = word | (WORD_BITS'(1) << bit_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			wv_q        <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_re) begin
				rd_valid_s1 <= wv_q[ram_raddr];
			end
			if (ram_we) begin
				wv_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_ALLOC) begin
							state_q <= (too_large || window_empty) ? ST_MUL : ST_SCAN;
						end else begin
							state_q <= bad_free ? ST_MUL : ST_FCHK;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						cnt_q   <= cnt_q + CNTW'(1);
						state_q <= ST_MUL;
					end else if (cur_w_q == l_word) begin
						state_q <= ST_MUL;
					end
				end
				ST_FCHK: begin
					if (!word[bit_q] && cnt_q != '0) begin
						cnt_q <= cnt_q - CNTW'(1);
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					slot_q <= '0;
					if (op == OP_ALLOC) begin
						cur_w_q  <= r_word;
						status_q <= too_large ? STS_TOO_LARGE : STS_NO_FREE;
					end else begin
						cur_w_q  <= AW'(num_ext >> L);
						bit_q    <= num_ext[L-1:0];
						status_q <= STS_BAD_FREE;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					slot_q   <= SW'((LW'(cur_w_q) << L) | LW'(hit_idx));
					status_q <= STS_OK;
				end else if (cur_w_q != l_word) begin
					cur_w_q <= cur_w_q + AW'(1);
				end
			end
			ST_FCHK: begin
				if (!word[bit_q]) begin
					status_q <= STS_OK;
				end
			end
			ST_MUL: begin
				prod_q <= PW'(slot_q) * PW'(cfg.slot_size);
			end
			default: ;
		endcase
		if (out_load) begin
			out_status_q <= status_q;
			out_slot_q   <= SLOT_NUM_W'(slot_q);
			out_off_q    <= OFFSET_W'(prod_q);
			out_empty_q  <= cnt_q == '0;
			out_cnt_q    <= IN_USE_W'(cnt_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {7'b0, out_cnt_q, out_empty_q, out_off_q, out_slot_q};

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(NUM_SLOTS))
		else $error("slot count above slot total");

	a_write_counts: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> cnt_q != $past(cnt_q))
		else $error("bitmap written without count change");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("bitmap read and write in one cycle");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STS_OK) |-> (m_tdata[29:0] == 30'd0))
		else $error("slot or offset on a failed response");
`endif

endmodule

`default_nettype wire
